// ----- hdl/mstu_pkg.sv -----
// Package: constants, payload types, sequencer states and slot bank command for the timeout unit.
package mstu_pkg;

  localparam int SLOTS         = 16;
  localparam int HORIZON_TICKS = 6000;
  localparam int IDX_W         = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W         = $clog2(SLOTS + 1);
  localparam int TICK_W        = 32;
  localparam int ID_W          = 8;
  localparam int IVL_W         = 16;
  localparam int ACT_W         = 5;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_REG    = 2'd1,
    OP_CANCEL = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_RELOAD = 2'd1,
    EV_REMOVE = 2'd2,
    EV_FULL   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATE,
    ST_WALK,
    ST_FIND,
    ST_APPLY,
    ST_MIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [ID_W-1:0]  timer_id;
    logic [IVL_W-1:0] interval;
    logic [IVL_W-1:0] reload_interval;
  } in_t;

  typedef struct packed {
    kind_t            event_kind;
    logic [ID_W-1:0]  fired_id;
    logic [ACT_W-1:0] active_count;
    logic             last;
  } out_t;

  typedef struct packed {
    logic              wr_dl_en;
    logic              wr_all_en;
    logic              drop_en;
    logic [IDX_W-1:0]  idx;
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] dl;
    logic [IVL_W-1:0]  rl;
  } bank_cmd_t;

  function automatic logic tick_before(input logic [TICK_W-1:0] a, input logic [TICK_W-1:0] b);
    logic [TICK_W-1:0] diff;
    diff = a - b;
    return diff[TICK_W-1];
  endfunction

endpackage

// ----- hdl/mstu_slot_bank.sv -----
// Slot bank: timer ids, deadlines and reloads with indexed write, gap-closing drop and read mux.
module mstu_slot_bank (
  input  logic                         clk,
  input  mstu_pkg::bank_cmd_t          cmd,
  input  logic [mstu_pkg::IDX_W-1:0]   rd_idx,
  output logic [mstu_pkg::ID_W-1:0]    rd_id,
  output logic [mstu_pkg::TICK_W-1:0]  rd_dl,
  output logic [mstu_pkg::IVL_W-1:0]   rd_rl
);

  logic [mstu_pkg::ID_W-1:0]   ids_r [mstu_pkg::SLOTS];
  logic [mstu_pkg::TICK_W-1:0] dls_r [mstu_pkg::SLOTS];
  logic [mstu_pkg::IVL_W-1:0]  rls_r [mstu_pkg::SLOTS];

  for (genvar g = 0; g < mstu_pkg::SLOTS; g++) begin : g_slot
    always_ff @(posedge clk) begin
      if (cmd.drop_en && (mstu_pkg::IDX_W'(g) >= cmd.idx)) begin
        if (g < mstu_pkg::SLOTS - 1) begin
          ids_r[g] <= ids_r[(g < mstu_pkg::SLOTS - 1) ? g + 1 : g];
          dls_r[g] <= dls_r[(g < mstu_pkg::SLOTS - 1) ? g + 1 : g];
          rls_r[g] <= rls_r[(g < mstu_pkg::SLOTS - 1) ? g + 1 : g];
        end
      end else if (cmd.wr_all_en && (cmd.idx == mstu_pkg::IDX_W'(g))) begin
        ids_r[g] <= cmd.id;
        dls_r[g] <= cmd.dl;
        rls_r[g] <= cmd.rl;
      end else if (cmd.wr_dl_en && (cmd.idx == mstu_pkg::IDX_W'(g))) begin
        dls_r[g] <= cmd.dl;
      end
    end
  end

  assign rd_id = ids_r[rd_idx];
  assign rd_dl = dls_r[rd_idx];
  assign rd_rl = rls_r[rd_idx];

endmodule

// ----- hdl/multi_slot_tick_timeout_unit_top.sv -----
// Top level: timeout slot sequencer with tick walk, id search, next-check minimum and result register.
// Sequence: a tick goes to GATE, then to WALK and MIN when the next check is due, then to DONE;
// register or cancel: FIND, APPLY for a register and MIN if a slot changed, DONE; WALK and DONE stall on out_ready.
// Throughput: one request at a time, one slot per cycle through the shared bank read port while
// no fired result waits on out_ready; in_ready rises with the last result.
// Reset (rst_n low, synchronous): tick counter, next check, slot count and control cleared.
module multi_slot_tick_timeout_unit_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mstu_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output mstu_pkg::out_t  out_data
);

  mstu_pkg::state_t            state_r, state_nxt;
  logic [1:0]                  op_r, op_nxt;
  logic [mstu_pkg::ID_W-1:0]   id_r, id_nxt;
  logic [mstu_pkg::IVL_W-1:0]  ivl_r, ivl_nxt;
  logic [mstu_pkg::IVL_W-1:0]  rld_r, rld_nxt;
  logic [mstu_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic [mstu_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [mstu_pkg::TICK_W-1:0] tick_r, tick_nxt;
  logic [mstu_pkg::TICK_W-1:0] next_r, next_nxt;
  logic                        pend_valid_r, pend_valid_nxt;
  mstu_pkg::out_t              pend_r, pend_nxt;
  logic                        rej_r, rej_nxt;
  logic                        out_valid_r, out_valid_nxt;
  mstu_pkg::out_t              out_r, out_nxt;

  mstu_pkg::bank_cmd_t         cmd;
  logic [mstu_pkg::ID_W-1:0]   rd_id;
  logic [mstu_pkg::TICK_W-1:0] rd_dl;
  logic [mstu_pkg::IVL_W-1:0]  rd_rl;
  logic                        out_free;
  logic                        idx_in;
  logic [mstu_pkg::TICK_W-1:0] horizon;

  mstu_slot_bank u_bank (
    .clk    (clk),
    .cmd    (cmd),
    .rd_idx (idx_r[mstu_pkg::IDX_W-1:0]),
    .rd_id  (rd_id),
    .rd_dl  (rd_dl),
    .rd_rl  (rd_rl)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign idx_in    = idx_r < cnt_r;
  assign horizon   = tick_r + mstu_pkg::TICK_W'(mstu_pkg::HORIZON_TICKS);
  assign in_ready  = (state_r == mstu_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mstu_pkg::ST_IDLE;
      cnt_r        <= '0;
      tick_r       <= '0;
      next_r       <= '0;
      pend_valid_r <= 1'b0;
      rej_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      tick_r       <= tick_nxt;
      next_r       <= next_nxt;
      pend_valid_r <= pend_valid_nxt;
      rej_r        <= rej_nxt;
      out_valid_r  <= out_valid_nxt;
      idx_r        <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    id_r   <= id_nxt;
    ivl_r  <= ivl_nxt;
    rld_r  <= rld_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    ivl_nxt        = ivl_r;
    rld_nxt        = rld_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    tick_nxt       = tick_r;
    next_nxt       = next_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    rej_nxt        = rej_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    cmd            = '0;
    cmd.idx        = idx_r[mstu_pkg::IDX_W-1:0];

    case (state_r)
      mstu_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_data.opcode;
          id_nxt         = in_data.timer_id;
          ivl_nxt        = in_data.interval;
          rld_nxt        = in_data.reload_interval;
          idx_nxt        = '0;
          rej_nxt        = 1'b0;
          pend_valid_nxt = 1'b0;
          case (in_data.opcode)
            mstu_pkg::OP_TICK: begin
              tick_nxt  = tick_r + 1'b1;
              state_nxt = mstu_pkg::ST_GATE;
            end
            mstu_pkg::OP_REG,
            mstu_pkg::OP_CANCEL: state_nxt = mstu_pkg::ST_FIND;
            default:             state_nxt = mstu_pkg::ST_DONE;
          endcase
        end
      end

      mstu_pkg::ST_GATE: begin
        if (mstu_pkg::tick_before(tick_r, next_r)) begin
          state_nxt = mstu_pkg::ST_DONE;
        end else begin
          state_nxt = mstu_pkg::ST_WALK;
        end
      end

      mstu_pkg::ST_WALK: begin
        if (!idx_in) begin
          next_nxt  = horizon;
          idx_nxt   = '0;
          state_nxt = mstu_pkg::ST_MIN;
        end else if (mstu_pkg::tick_before(tick_r, rd_dl)) begin
          idx_nxt = idx_r + 1'b1;
        end else if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = pend_r;
          end
          pend_valid_nxt    = 1'b1;
          pend_nxt.fired_id = rd_id;
          pend_nxt.last     = 1'b0;
          if (rd_rl != '0) begin
            pend_nxt.event_kind   = mstu_pkg::EV_RELOAD;
            pend_nxt.active_count = mstu_pkg::ACT_W'(cnt_r);
            cmd.wr_dl_en          = 1'b1;
            cmd.dl                = tick_r + mstu_pkg::TICK_W'(rd_rl);
            idx_nxt               = idx_r + 1'b1;
          end else begin
            pend_nxt.event_kind   = mstu_pkg::EV_REMOVE;
            pend_nxt.active_count = mstu_pkg::ACT_W'(cnt_r - 1'b1);
            cmd.drop_en           = 1'b1;
            cnt_nxt               = cnt_r - 1'b1;
          end
        end
      end

      mstu_pkg::ST_FIND: begin
        if (idx_in) begin
          if (rd_id == id_r) begin
            if (op_r == mstu_pkg::OP_REG) begin
              state_nxt = mstu_pkg::ST_APPLY;
            end else begin
              cmd.drop_en = 1'b1;
              cnt_nxt     = cnt_r - 1'b1;
              next_nxt    = horizon;
              idx_nxt     = '0;
              state_nxt   = mstu_pkg::ST_MIN;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else if (op_r == mstu_pkg::OP_REG) begin
          if (cnt_r >= mstu_pkg::CNT_W'(mstu_pkg::SLOTS)) begin
            rej_nxt   = 1'b1;
            state_nxt = mstu_pkg::ST_DONE;
          end else begin
            state_nxt = mstu_pkg::ST_APPLY;
          end
        end else begin
          state_nxt = mstu_pkg::ST_DONE;
        end
      end

      mstu_pkg::ST_APPLY: begin
        cmd.wr_all_en = 1'b1;
        cmd.id        = id_r;
        cmd.dl        = tick_r + mstu_pkg::TICK_W'(ivl_r);
        cmd.rl        = rld_r;
        if (idx_r == cnt_r) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        next_nxt  = horizon;
        idx_nxt   = '0;
        state_nxt = mstu_pkg::ST_MIN;
      end

      mstu_pkg::ST_MIN: begin
        if (idx_in) begin
          if (mstu_pkg::tick_before(rd_dl, next_r)) begin
            next_nxt = rd_dl;
          end
          idx_nxt = idx_r + 1'b1;
        end else begin
          state_nxt = mstu_pkg::ST_DONE;
        end
      end

      mstu_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (pend_valid_r) begin
            out_nxt      = pend_r;
            out_nxt.last = 1'b1;
          end else if (rej_r) begin
            out_nxt.event_kind   = mstu_pkg::EV_FULL;
            out_nxt.fired_id     = id_r;
            out_nxt.active_count = mstu_pkg::ACT_W'(cnt_r);
            out_nxt.last         = 1'b1;
          end else begin
            out_nxt.event_kind   = mstu_pkg::EV_NONE;
            out_nxt.fired_id     = '0;
            out_nxt.active_count = mstu_pkg::ACT_W'(cnt_r);
            out_nxt.last         = 1'b1;
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = mstu_pkg::ST_IDLE;
        end
      end

      default: state_nxt = mstu_pkg::ST_IDLE;
    endcase
  end

endmodule
